// ===== design/bidrf_pkg.sv =====
package bidrf_pkg;

	localparam int PosBitsDefault  = 32;
	localparam int MaxDepthDefault = 64;

	// Width of the decimal length accumulator and of the skip counter.
	localparam int LenBits = 32;

	// Width of the offset fields on the result channel.
	localparam int OutBits = 32;

	localparam int          KeyLen     = 6;
	localparam logic [2:0]  KeyLenCode = 3'd6;

	localparam logic [7:0] CharDict  = 8'h64;  // 'd'
	localparam logic [7:0] CharList  = 8'h6C;  // 'l'
	localparam logic [7:0] CharEnd   = 8'h65;  // 'e'
	localparam logic [7:0] CharColon = 8'h3A;  // ':'
	localparam logic [7:0] CharZero  = 8'h30;  // '0'
	localparam logic [7:0] CharNine  = 8'h39;  // '9'

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_EXPECT = 2'd1,
		PH_SCAN   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_NOKEY    = 3'd1,
		ST_NOTDICT  = 3'd2,
		ST_UNCLOSED = 3'd3,
		ST_DEEP     = 3'd4
	} status_t;

	// Characters of the key text "4:info".
	function automatic logic [7:0] key_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h34;
			3'd1:    ch = 8'h3A;
			3'd2:    ch = 8'h69;
			3'd3:    ch = 8'h6E;
			3'd4:    ch = 8'h66;
			3'd5:    ch = 8'h6F;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== design/bencode_info_dict_range_finder.sv =====
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-----------------------------------
// in      | input     | in_valid, in_stall  | data_byte[7:0], last_byte
// out     | output    | out_valid, out_stall| status[2:0], info_start[31:0],
//         |           |                     | info_end[31:0]
//
// One item is taken every cycle while in_stall is low; an item's result is
// registered in the result register as the item leaves the input register.
// The scanner state is updated by one registered pass per byte; the length
// accumulator multiply-by-ten add sets the longest path.
// arst_n clears all control state; the block then searches for the key.
// A stalled result holds the pipeline: in_stall rises only while the input
// register is full and the result register is full and stalled.
// After a last_byte item the block returns to its reset state.
module bencode_info_dict_range_finder #(
	parameter int POS_BITS  = bidrf_pkg::PosBitsDefault,
	parameter int MAX_DEPTH = bidrf_pkg::MaxDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] info_start,
	output logic [31:0] info_end
);

	localparam int DepthBits = $clog2(MAX_DEPTH + 1);
	localparam int LenBits   = bidrf_pkg::LenBits;
	localparam int OutBits   = bidrf_pkg::OutBits;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Scanner state
	bidrf_pkg::phase_t     phase_q, phase_n;
	logic [2:0]            kcnt_q, kcnt_n;
	logic [POS_BITS-1:0]   pos_q, pos_n;
	logic [POS_BITS-1:0]   start_q, start_n;
	logic [DepthBits-1:0]  depth_q, depth_n;
	logic [LenBits-1:0]    acc_q, acc_n;
	logic                  digits_q, digits_n;
	logic [LenBits-1:0]    skip_q, skip_n;

	// Result register
	logic                  out_valid_q;
	bidrf_pkg::status_t    status_q;
	logic [OutBits-1:0]    start_out_q;
	logic [OutBits-1:0]    end_out_q;

	// Result of the current item
	logic                  res_hit;
	bidrf_pkg::status_t    res_status;
	logic [OutBits-1:0]    res_start;
	logic [OutBits-1:0]    res_end;

	logic                  advance;
	logic                  step;
	logic [7:0]            c;
	logic                  is_digit;
	logic [LenBits+3:0]    acc_ext;
	logic [LenBits+3:0]    acc_ten;
	logic [LenBits-1:0]    acc_sat;
	logic                  plain;
	logic                  found;
	logic                  deep;
	logic [POS_BITS+OutBits-1:0] start_wide;
	logic [POS_BITS+OutBits-1:0] end_wide;
	bidrf_pkg::phase_t     phase_pre;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign c        = data_s1;
	assign is_digit = (c >= bidrf_pkg::CharZero) && (c <= bidrf_pkg::CharNine);
	assign acc_ext  = {4'b0, acc_q};
	assign acc_ten  = (acc_ext << 3) + (acc_ext << 1) + {{LenBits{1'b0}}, c[3:0]};
	assign acc_sat  = (|acc_ten[LenBits+3:LenBits]) ? {LenBits{1'b1}} : acc_ten[LenBits-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Next state of the scanner for the byte in the input register.
	always_comb begin
		phase_pre = phase_q;
		kcnt_n    = kcnt_q;
		start_n   = start_q;
		depth_n   = depth_q;
		acc_n     = acc_q;
		digits_n  = digits_q;
		skip_n    = skip_q;
		plain     = 1'b1;
		found     = 1'b0;
		deep      = 1'b0;
		case (phase_q)
			bidrf_pkg::PH_SEARCH: begin
				if (kcnt_q < bidrf_pkg::KeyLenCode && c == bidrf_pkg::key_char(kcnt_q)) begin
					kcnt_n = kcnt_q + 3'd1;
				end else begin
					kcnt_n = (c == bidrf_pkg::key_char(3'd0)) ? 3'd1 : 3'd0;
				end
				if (kcnt_n >= bidrf_pkg::KeyLenCode) begin
					phase_pre = bidrf_pkg::PH_EXPECT;
				end
			end
			bidrf_pkg::PH_EXPECT: begin
				if (c == bidrf_pkg::CharDict) begin
					start_n   = pos_q;
					depth_n   = DepthBits'(1);
					digits_n  = 1'b0;
					acc_n     = '0;
					skip_n    = '0;
					phase_pre = bidrf_pkg::PH_SCAN;
				end else begin
					phase_pre = bidrf_pkg::PH_DONE;
				end
			end
			bidrf_pkg::PH_SCAN: begin
				if (skip_q != '0) begin
					skip_n = skip_q - LenBits'(1);
					plain  = 1'b0;
				end else if (digits_q) begin
					if (is_digit) begin
						acc_n = acc_sat;
						plain = 1'b0;
					end else if (c == bidrf_pkg::CharColon) begin
						skip_n   = acc_q;
						digits_n = 1'b0;
						plain    = 1'b0;
					end else begin
						digits_n = 1'b0;
					end
				end
				if (plain) begin
					if (c == bidrf_pkg::CharDict || c == bidrf_pkg::CharList) begin
						if (depth_q >= DepthBits'(MAX_DEPTH)) begin
							deep      = 1'b1;
							phase_pre = bidrf_pkg::PH_DONE;
						end else begin
							depth_n = depth_q + DepthBits'(1);
						end
					end else if (c == bidrf_pkg::CharEnd) begin
						depth_n = (depth_q != '0) ? depth_q - DepthBits'(1) : '0;
						if (depth_n == '0) begin
							found     = 1'b1;
							phase_pre = bidrf_pkg::PH_DONE;
						end
					end else if (is_digit) begin
						digits_n = 1'b1;
						acc_n    = {{(LenBits-4){1'b0}}, c[3:0]};
					end
				end
			end
			default: begin
			end
		endcase

		pos_n   = pos_q + POS_BITS'(1);
		phase_n = phase_pre;
		if (last_s1) begin
			phase_n  = bidrf_pkg::PH_SEARCH;
			kcnt_n   = '0;
			pos_n    = '0;
			start_n  = '0;
			depth_n  = '0;
			acc_n    = '0;
			digits_n = 1'b0;
			skip_n   = '0;
		end
	end

	assign start_wide = {{OutBits{1'b0}}, start_q};
	assign end_wide   = {{OutBits{1'b0}}, pos_q + POS_BITS'(1)};

	// Result of the byte in the input register.
	always_comb begin
		res_hit    = 1'b0;
		res_status = bidrf_pkg::ST_FOUND;
		res_start  = '0;
		res_end    = '0;
		if (found) begin
			res_hit   = 1'b1;
			res_start = start_wide[OutBits-1:0];
			res_end   = end_wide[OutBits-1:0];
		end else if (deep) begin
			res_hit    = 1'b1;
			res_status = bidrf_pkg::ST_DEEP;
		end else if (phase_q == bidrf_pkg::PH_EXPECT && phase_pre == bidrf_pkg::PH_DONE) begin
			res_hit    = 1'b1;
			res_status = bidrf_pkg::ST_NOTDICT;
		end else if (last_s1) begin
			case (phase_pre)
				bidrf_pkg::PH_SEARCH: begin
					res_hit    = 1'b1;
					res_status = bidrf_pkg::ST_NOKEY;
				end
				bidrf_pkg::PH_EXPECT: begin
					res_hit    = 1'b1;
					res_status = bidrf_pkg::ST_NOTDICT;
				end
				bidrf_pkg::PH_SCAN: begin
					res_hit    = 1'b1;
					res_status = bidrf_pkg::ST_UNCLOSED;
				end
				default: begin
					res_hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bidrf_pkg::PH_SEARCH;
			kcnt_q   <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			depth_q  <= '0;
			acc_q    <= '0;
			digits_q <= 1'b0;
			skip_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			kcnt_q   <= kcnt_n;
			pos_q    <= pos_n;
			start_q  <= start_n;
			depth_q  <= depth_n;
			acc_q    <= acc_n;
			digits_q <= digits_n;
			skip_q   <= skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_hit) begin
			status_q    <= res_status;
			start_out_q <= res_start;
			end_out_q   <= res_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign info_start = start_out_q;
	assign info_end   = end_out_q;

	// A stream's last item leaves the scanner in its reset state.
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> phase_q == bidrf_pkg::PH_SEARCH && pos_q == '0 && kcnt_q == '0)
		else $error("scanner not rearmed after the last item");

	// While scanning, the opening dictionary is still open.
	a_scan_depth: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bidrf_pkg::PH_SCAN |-> depth_q != '0)
		else $error("scan phase with zero depth");

	// Skipping and reading a length prefix only happen while scanning, never together.
	a_skip_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q != '0 || digits_q) |-> phase_q == bidrf_pkg::PH_SCAN && !(skip_q != '0 && digits_q))
		else $error("string skip or length prefix outside the scan");

	// A found span comes only from a closing marker seen while scanning.
	a_found_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		step && found |-> phase_q == bidrf_pkg::PH_SCAN && c == bidrf_pkg::CharEnd)
		else $error("span reported outside the scan");

	// Depth never exceeds the bound.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepthBits'(MAX_DEPTH))
		else $error("nesting depth above the bound");

endmodule

// ===== verif/bidrf_span_checker.sv =====
`timescale 1ns / 1ps

module bidrf_span_checker #(
	parameter int POS_BITS  = bidrf_pkg::PosBitsDefault,
	parameter int MAX_DEPTH = bidrf_pkg::MaxDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [31:0] info_start,
	input  logic [31:0] info_end,
	output int          fail_count,
	output int          pending
);

	localparam int KeyLen  = bidrf_pkg::KeyLen;
	localparam int LenBits = bidrf_pkg::LenBits;
	localparam logic [8*KeyLen-1:0] KEY_TEXT = "4:info";

	typedef struct packed {
		bidrf_pkg::status_t st;
		logic [31:0]        first;
		logic [31:0]        past;
	} span_report_t;

	bidrf_pkg::phase_t     scan_phase;
	logic [2:0]            key_hits;
	logic [POS_BITS-1:0]   offset;
	logic [POS_BITS-1:0]   dict_start;
	logic [6:0]            depth;
	logic [LenBits-1:0]    len_acc;
	logic [LenBits-1:0]    skip_left;
	logic                  reading_len;
	span_report_t          span_reports[$];

	function automatic logic is_digit(input logic [7:0] c);
		return c >= bidrf_pkg::CharZero && c <= bidrf_pkg::CharNine;
	endfunction

	task automatic clear_scan();
		scan_phase  = bidrf_pkg::PH_SEARCH;
		key_hits    = '0;
		offset      = '0;
		dict_start  = '0;
		depth       = '0;
		len_acc     = '0;
		skip_left   = '0;
		reading_len = 1'b0;
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic lst, output logic got,
			output span_report_t r);
		logic                plain;
		logic [63:0]         v;
		logic [POS_BITS-1:0] here;
		logic [POS_BITS-1:0] nxt;
		got  = 1'b0;
		r    = '{bidrf_pkg::ST_FOUND, 32'd0, 32'd0};
		here = offset;
		nxt  = here + 1'b1;
		case (scan_phase)
			bidrf_pkg::PH_SEARCH: begin
				if (key_hits < bidrf_pkg::KeyLenCode &&
						c == KEY_TEXT[8*(KeyLen-1-int'(key_hits)) +: 8])
					key_hits = key_hits + 3'd1;
				else
					key_hits = (c == KEY_TEXT[8*(KeyLen-1) +: 8]) ? 3'd1 : 3'd0;
				if (key_hits >= bidrf_pkg::KeyLenCode)
					scan_phase = bidrf_pkg::PH_EXPECT;
			end
			bidrf_pkg::PH_EXPECT: begin
				if (c == bidrf_pkg::CharDict) begin
					dict_start  = here;
					depth       = 7'd1;
					reading_len = 1'b0;
					len_acc     = '0;
					skip_left   = '0;
					scan_phase  = bidrf_pkg::PH_SCAN;
				end else begin
					got        = 1'b1;
					r.st       = bidrf_pkg::ST_NOTDICT;
					scan_phase = bidrf_pkg::PH_DONE;
				end
			end
			bidrf_pkg::PH_SCAN: begin
				plain = 1'b1;
				if (skip_left != 0) begin
					skip_left = skip_left - 1'b1;
					plain     = 1'b0;
				end else if (reading_len) begin
					if (is_digit(c)) begin
						// The decimal length sticks at all ones once it overflows.
						v       = 64'(len_acc) * 64'd10 + 64'(c - bidrf_pkg::CharZero);
						len_acc = (v > 64'hFFFF_FFFF) ? '1 : v[LenBits-1:0];
						plain   = 1'b0;
					end else if (c == bidrf_pkg::CharColon) begin
						skip_left   = len_acc;
						reading_len = 1'b0;
						plain       = 1'b0;
					end else begin
						reading_len = 1'b0;
					end
				end
				if (plain) begin
					if (c == bidrf_pkg::CharDict || c == bidrf_pkg::CharList) begin
						if (int'(depth) + 1 > MAX_DEPTH) begin
							got        = 1'b1;
							r.st       = bidrf_pkg::ST_DEEP;
							scan_phase = bidrf_pkg::PH_DONE;
						end else begin
							depth = depth + 7'd1;
						end
					end else if (c == bidrf_pkg::CharEnd) begin
						if (depth != 0)
							depth = depth - 7'd1;
						if (depth == 0) begin
							got        = 1'b1;
							r          = '{bidrf_pkg::ST_FOUND, 32'(dict_start), 32'(nxt)};
							scan_phase = bidrf_pkg::PH_DONE;
						end
					end else if (is_digit(c)) begin
						reading_len = 1'b1;
						len_acc     = LenBits'(c - bidrf_pkg::CharZero);
					end
				end
			end
			default: ;
		endcase
		offset = nxt;
		if (lst) begin
			if (!got) begin
				case (scan_phase)
					bidrf_pkg::PH_SEARCH: begin got = 1'b1; r.st = bidrf_pkg::ST_NOKEY; end
					bidrf_pkg::PH_EXPECT: begin got = 1'b1; r.st = bidrf_pkg::ST_NOTDICT; end
					bidrf_pkg::PH_SCAN: begin got = 1'b1; r.st = bidrf_pkg::ST_UNCLOSED; end
					default: ;
				endcase
			end
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_report_t want;
		span_report_t made;
		logic         got;
		if (!arst_n) begin
			clear_scan();
			span_reports.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_byte(data_byte, last_byte, got, made);
				if (got)
					span_reports.push_back(made);
			end
			if (out_valid && !out_stall) begin
				if (span_reports.size() == 0) begin
					$error("unexpected result: status %0d, info_start %0d, info_end %0d",
						status, info_start, info_end);
					fail_count++;
				end else begin
					want = span_reports.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fail_count++;
					end
					if (info_start !== want.first) begin
						$error("info_start: expected %0d, actual %0d", want.first, info_start);
						fail_count++;
					end
					if (info_end !== want.past) begin
						$error("info_end: expected %0d, actual %0d", want.past, info_end);
						fail_count++;
					end
				end
			end
		end
		pending = span_reports.size();
	end

endmodule

// ===== verif/tb_bencode_info_dict_range_finder.sv =====
`timescale 1ns / 1ps

module tb_bencode_info_dict_range_finder;

	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN      = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] info_start;
	logic [31:0] info_end;
	int          fail_count;
	int          pending;

	logic [7:0]  file_bytes[$];
	int          bytes_sent;
	int          idle_cycles;

	bencode_info_dict_range_finder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.info_start (info_start),
		.info_end   (info_end)
	);

	bidrf_span_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.info_start (info_start),
		.info_end   (info_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Nothing moving on either channel for too long means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Back-pressure on the result side: free runs broken by stalls of mixed length.
	initial begin
		int free_len;
		int stall_len;
		out_stall = 1'b0;
		forever begin
			free_len  = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
			stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
				: $urandom_range(10, 30);
			repeat (free_len) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			repeat (stall_len) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	task automatic push_str(input string s);
		foreach (s[i])
			file_bytes.push_back(s[i]);
	endtask

	task automatic push_noise(input int n);
		repeat (n)
			file_bytes.push_back(8'($urandom));
	endtask

	// A length-prefixed string whose content is laced with markers and digits.
	task automatic push_lenstring();
		string marks;
		int    n;
		marks = "dle:59";
		n     = $urandom_range(0, 5);
		push_str($sformatf("%0d:", n));
		repeat (n)
			file_bytes.push_back($urandom_range(0, 1) ? 8'($urandom)
				: marks[$urandom_range(0, 5)]);
	endtask

	task automatic push_body(input int budget, input bit close_all);
		int d;
		d = 1;
		while (budget > 0 && d > 0) begin
			budget--;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if (d < 4) begin
						file_bytes.push_back($urandom_range(0, 1) ? bidrf_pkg::CharDict
							: bidrf_pkg::CharList);
						d++;
					end
				end
				3, 4, 5: begin
					file_bytes.push_back(bidrf_pkg::CharEnd);
					d--;
				end
				6, 7, 8: push_lenstring();
				default: begin
					// Digits followed by one random byte.
					push_str($sformatf("%0d", $urandom_range(0, 99)));
					push_noise(1);
				end
			endcase
		end
		if (close_all)
			repeat (d)
				file_bytes.push_back(bidrf_pkg::CharEnd);
	endtask

	task automatic send_file();
		bit quiet;
		int gap;
		quiet = ($urandom_range(0, 3) == 0);
		foreach (file_bytes[i]) begin
			if (quiet)
				gap = 0;
			else if ($urandom_range(0, 99) < 70)
				gap = 0;
			else if ($urandom_range(0, 99) < 75)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 25);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			@(negedge clk);
			in_valid  <= 1'b1;
			data_byte <= file_bytes[i];
			last_byte <= (i == file_bytes.size() - 1);
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			bytes_sent++;
		end
		file_bytes.delete();
	endtask

	initial begin
		int kind;
		int n;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		last_byte   = 1'b0;
		arst_n      = 1'b0;
		bytes_sent  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Short directed files: no key at all, a minimal dictionary, the key as
		// the final byte, and a wrong byte after the key.
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'hFF);
		send_file();
		push_str("4:infode");
		send_file();
		push_str("4:info");
		send_file();
		push_str("4:infox");
		send_file();

		while (bytes_sent < 450) begin
			kind = $urandom_range(0, 99);
			if (kind < 55 || kind >= 90) begin
				push_noise($urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0)
					push_str("4:in");
				push_str("4:info");
				file_bytes.push_back(bidrf_pkg::CharDict);
				push_body($urandom_range(1, 8), 1'b1);
				// Bytes after a finished span must be ignored.
				push_noise((kind >= 90) ? $urandom_range(5, 15) : $urandom_range(0, 3));
			end else if (kind < 65) begin
				push_str("4:info");
				file_bytes.push_back(bidrf_pkg::CharDict);
				push_body($urandom_range(1, 8), 1'b0);
			end else if (kind < 70) begin
				// A long length prefix that may saturate and runs past the end.
				push_str("4:info");
				file_bytes.push_back(bidrf_pkg::CharDict);
				repeat ($urandom_range(10, 14))
					file_bytes.push_back(8'(bidrf_pkg::CharZero + $urandom_range(0, 9)));
				file_bytes.push_back(bidrf_pkg::CharColon);
				push_noise($urandom_range(0, 4));
			end else if (kind < 75) begin
				push_str("4:info");
				push_noise(1 + $urandom_range(0, 2));
			end else if (kind < 78) begin
				push_noise($urandom_range(0, 3));
				push_str("4:info");
			end else if (kind < 81) begin
				// Nesting just below the bound, right up to it, and one level beyond it.
				n = $urandom_range(62, 64);
				push_str("4:info");
				file_bytes.push_back(bidrf_pkg::CharDict);
				repeat (n)
					file_bytes.push_back($urandom_range(0, 1) ? bidrf_pkg::CharDict
						: bidrf_pkg::CharList);
				repeat (n + 1)
					file_bytes.push_back(bidrf_pkg::CharEnd);
			end else begin
				push_noise($urandom_range(1, 12));
				if ($urandom_range(0, 1))
					push_str("44:inf");
			end
			send_file();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
